// ===== src/tmhq_pkg.sv =====
// Package for the timer min-heap queue: request and result payloads,
// heap entry types, command and status codes, sequencer states.
// No dependencies.
`default_nettype none
package tmhq_pkg;

    localparam int CW = 6;   // heap count and slot position width
    localparam int IW = 7;   // child index width, holds 2 * slot + 2

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_ADJUST = 3'd1;
    localparam logic [2:0] CMD_FIRE   = 3'd2;
    localparam logic [2:0] CMD_POP    = 3'd3;
    localparam logic [2:0] CMD_EXPIRE = 3'd4;
    localparam logic [2:0] CMD_CLEAR  = 3'd5;

    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_FIRED  = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [9:0]  timer_id;
        logic [30:0] timeout_ms;
        logic [47:0] now_ms;
    } req_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [1:0]  status;
        logic [9:0]  fired_id;
        logic [47:0] remaining_ms;
        logic        none_pending;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [47:0] dl;
        logic [9:0]  own;
    } entry_t;

    // Cell read-out: stored entry and whether its deadline is later than the key.
    typedef struct packed {
        entry_t e;
        logic   gt;
    } cell_rd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_DOWN,
        S_UP,
        S_FIX,
        S_EMIT,
        S_EXPIRE,
        S_CLEAN
    } state_t;

endpackage
`default_nettype wire

// ===== src/tmhq_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on tmhq_pkg.
`default_nettype none
interface tmhq_req_if;
    logic            valid;
    logic            ready;
    tmhq_pkg::req_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tmhq_rsp_if;
    logic            valid;
    logic            ready;
    tmhq_pkg::rsp_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/timer_min_heap_queue.sv =====
// Timer queue as an indexed binary min-heap kept in a row of slot cells.
// Steps: a lookup, then per sift direction one step per level moved plus one to stop,
// one to record the slot and one to load the result; a plain request skips the sifts
// and the slot record, and expire runs these steps once per fired timer.
// One request at a time, accepted the cycle after the previous last result is loaded.
// Reset empties the heap, then the id-to-slot RAM is zeroed entry by entry before requests are accepted.
`default_nettype none
module timer_min_heap_queue #(
    parameter int HEAP_CAPACITY = 32,
    parameter int ID_SPACE      = 1024
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tmhq_req_if.sink   request,
    tmhq_rsp_if.source result
);
    import tmhq_pkg::*;

    localparam int SW = $clog2(HEAP_CAPACITY);
    localparam int AW = $clog2(ID_SPACE);

    state_t       state_reg, state_next;
    req_t         req_reg, req_next;
    logic [47:0]  dl_reg, dl_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    entry_t       walk_reg, walk_next;
    logic         moved_reg, moved_next;
    rsp_t         pend_reg, pend_next;
    logic         ret_exp_reg, ret_exp_next;
    logic         out_valid_reg, out_valid_next;
    rsp_t         out_reg, out_next;
    logic [AW-1:0] clr_reg, clr_next;

    logic [IW-1:0] a_idx, b_idx, wa_idx, wb_idx;
    logic          wa_en, wb_en;
    entry_t        wa_data, wb_data;
    cell_rd_t      rd_a, rd_b;
    cell_rd_t      cell_rd [HEAP_CAPACITY];

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [9:0]    ram_wown;
    logic [CW-1:0] ram_wslot;
    logic [SW-1:0] ram_rdata;

    logic [48:0]   sum;
    logic [CW-1:0] slot, last_slot, parent;
    logic [IW-1:0] l_idx, r_idx, n_ext;
    logic          id_ok, known;
    cell_rd_t      pick;
    logic [IW-1:0] pick_idx;
    logic [16:0]   id_w, own_w;

    // Heap slot cells.
    for (genvar i = 0; i < HEAP_CAPACITY; i++)
    begin : g_cell
        logic   en;
        entry_t d;
        assign en = (wa_en && wa_idx == IW'(i)) || (wb_en && wb_idx == IW'(i));
        assign d  = (wa_en && wa_idx == IW'(i)) ? wa_data : wb_data;
        tmhq_cell u_cell (
            .clk      (clk),
            .wr_en    (en),
            .wr_entry (d),
            .key      (walk_reg.dl),
            .rd       (cell_rd[i])
        );
    end

    always_comb
    begin
        rd_a = '0;
        rd_b = '0;
        for (int i = 0; i < HEAP_CAPACITY; i++)
        begin
            if (a_idx == IW'(i)) rd_a = cell_rd[i];
            if (b_idx == IW'(i)) rd_b = cell_rd[i];
        end
    end

    assign id_w      = 17'(request.data.timer_id);
    assign own_w     = 17'(ram_wown);
    assign ram_raddr = id_w[AW-1:0];
    assign ram_waddr = (state_reg == S_CLEAN) ? clr_reg : own_w[AW-1:0];

    tmhq_ram #(.WIDTH(SW), .DEPTH(ID_SPACE)) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wslot[SW-1:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAN;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            ret_exp_reg   <= 1'b0;
            moved_reg     <= 1'b0;
            clr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            ret_exp_reg   <= ret_exp_next;
            moved_reg     <= moved_next;
            clr_reg       <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        dl_reg   <= dl_next;
        pos_reg  <= pos_next;
        walk_reg <= walk_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign request.ready = (state_reg == S_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.data   = out_reg;

    assign sum       = {1'b0, request.data.now_ms} + 49'(request.data.timeout_ms);
    assign slot      = CW'(ram_rdata);
    assign last_slot = count_reg - 1'b1;
    assign parent    = (pos_reg - 1'b1) >> 1;
    assign l_idx     = {pos_reg, 1'b1};
    assign r_idx     = l_idx + 1'b1;
    assign n_ext     = IW'(count_reg);
    assign id_ok     = 17'(req_reg.timer_id) < 17'(ID_SPACE);
    assign known     = id_ok && (slot < count_reg) && (rd_a.e.own == req_reg.timer_id);

    always_comb
    begin
        if (r_idx >= n_ext || rd_a.e.dl < rd_b.e.dl)
        begin
            pick = rd_a;
            pick_idx = l_idx;
        end
        else
        begin
            pick = rd_b;
            pick_idx = r_idx;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        dl_next        = dl_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        walk_next      = walk_reg;
        moved_next     = moved_reg;
        pend_next      = pend_reg;
        ret_exp_next   = ret_exp_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        clr_next       = clr_reg;
        a_idx = '0;
        b_idx = IW'(last_slot);
        wa_en = 1'b0;
        wb_en = 1'b0;
        wa_idx = '0;
        wb_idx = '0;
        wa_data = walk_reg;
        wb_data = walk_reg;
        ram_we = 1'b0;
        ram_wown = walk_reg.own;
        ram_wslot = pos_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAN:
            begin
                // Zero every id-to-slot entry so that lookups never return unknown data.
                ram_we = 1'b1;
                ram_wslot = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(ID_SPACE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (request.valid)
                begin
                    req_next   = request.data;
                    dl_next    = sum[48] ? '1 : sum[47:0];
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                a_idx = (req_reg.command == CMD_POP) ? '0 : IW'(slot);
                pend_next = '0;
                pend_next.last = 1'b1;
                ret_exp_next = 1'b0;
                moved_next = 1'b0;
                state_next = S_EMIT;
                unique case (req_reg.command)
                    CMD_ADD, CMD_ADJUST:
                    begin
                        if (!id_ok || (!known && req_reg.command == CMD_ADJUST))
                        begin
                            pend_next.status = ST_NOTFOUND;
                        end
                        else if (known)
                        begin
                            walk_next = '{dl: dl_reg, own: req_reg.timer_id};
                            wa_en = 1'b1;
                            wa_idx = IW'(slot);
                            wa_data = '{dl: dl_reg, own: req_reg.timer_id};
                            pos_next = slot;
                            state_next = S_DOWN;
                        end
                        else if (7'(count_reg) >= 7'(HEAP_CAPACITY))
                        begin
                            pend_next.status = ST_FULL;
                        end
                        else
                        begin
                            walk_next = '{dl: dl_reg, own: req_reg.timer_id};
                            wa_en = 1'b1;
                            wa_idx = IW'(count_reg);
                            wa_data = '{dl: dl_reg, own: req_reg.timer_id};
                            pos_next = count_reg;
                            count_next = count_reg + 1'b1;
                            state_next = S_UP;
                        end
                    end
                    CMD_FIRE, CMD_POP:
                    begin
                        if ((req_reg.command == CMD_FIRE && known) ||
                            (req_reg.command == CMD_POP && count_reg != '0))
                        begin
                            pend_next.result_kind = KIND_FIRED;
                            pend_next.fired_id = rd_a.e.own;
                            count_next = last_slot;
                            if (a_idx < IW'(last_slot))
                            begin
                                walk_next = rd_b.e;
                                wa_en = 1'b1;
                                wa_idx = a_idx;
                                wa_data = rd_b.e;
                                pos_next = CW'(a_idx);
                                state_next = S_DOWN;
                            end
                        end
                        else
                        begin
                            pend_next.status = ST_NOTFOUND;
                        end
                    end
                    CMD_EXPIRE:
                    begin
                        state_next = S_EXPIRE;
                    end
                    CMD_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DOWN:
            begin
                a_idx = l_idx;
                b_idx = r_idx;
                if (l_idx >= n_ext || pick.gt)
                begin
                    state_next = moved_reg ? S_FIX : S_UP;
                end
                else
                begin
                    wa_en = 1'b1;
                    wa_idx = IW'(pos_reg);
                    wa_data = pick.e;
                    wb_en = 1'b1;
                    wb_idx = pick_idx;
                    ram_we = 1'b1;
                    ram_wown = pick.e.own;
                    pos_next = CW'(pick_idx);
                    moved_next = 1'b1;
                end
            end
            S_UP:
            begin
                a_idx = IW'(parent);
                if (pos_reg != '0 && rd_a.gt)
                begin
                    wa_en = 1'b1;
                    wa_idx = IW'(pos_reg);
                    wa_data = rd_a.e;
                    wb_en = 1'b1;
                    wb_idx = IW'(parent);
                    ram_we = 1'b1;
                    ram_wown = rd_a.e.own;
                    pos_next = parent;
                end
                else
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                ram_we = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_next = pend_reg;
                    state_next = ret_exp_reg ? S_EXPIRE : S_IDLE;
                end
            end
            S_EXPIRE:
            begin
                pend_next = '0;
                moved_next = 1'b0;
                state_next = S_EMIT;
                if (count_reg != '0 && rd_a.e.dl <= req_reg.now_ms)
                begin
                    pend_next.result_kind = KIND_FIRED;
                    pend_next.fired_id = rd_a.e.own;
                    ret_exp_next = 1'b1;
                    count_next = last_slot;
                    if (last_slot != '0)
                    begin
                        walk_next = rd_b.e;
                        wa_en = 1'b1;
                        wa_data = rd_b.e;
                        pos_next = '0;
                        state_next = S_DOWN;
                    end
                end
                else
                begin
                    pend_next.result_kind = KIND_REPORT;
                    pend_next.last = 1'b1;
                    ret_exp_next = 1'b0;
                    if (count_reg != '0)
                    begin
                        pend_next.remaining_ms = rd_a.e.dl - req_reg.now_ms;
                    end
                    else
                    begin
                        pend_next.none_pending = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        7'(count_reg) <= 7'(HEAP_CAPACITY))
        else $error("heap count beyond capacity");

    a_down_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DOWN) |-> (pos_reg < count_reg))
        else $error("sift position outside heap");

    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> (state_reg == S_LOOK))
        else $error("accepted request not looked up");

    a_fix_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIX) |=> (state_reg == S_EMIT))
        else $error("slot record not followed by result");
endmodule
`default_nettype wire

// ===== src/tmhq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tmhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

// ===== src/tmhq_cell.sv =====
// One heap slot: holds a deadline and its owner id, and compares the
// deadline against the walking entry's key. Depends on tmhq_pkg.
`default_nettype none
module tmhq_cell (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire tmhq_pkg::entry_t  wr_entry,
    input  wire logic [47:0]       key,
    output tmhq_pkg::cell_rd_t     rd
);
    import tmhq_pkg::*;

    entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg <= wr_entry;
        end
    end

    assign rd = '{e: entry_reg, gt: (entry_reg.dl > key)};
endmodule
`default_nettype wire
